// ===== rtl/core/sgte_pkg.sv =====
package sgte_pkg;

  localparam int MAX_DIM = 32;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int AW      = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DIM_LIM = (MAX_DIM < 32) ? MAX_DIM : 32;
  localparam int EW      = 12;

  localparam logic [31:0] QNAN32     = 32'h7FC0_0000;
  localparam logic [31:0] NEG_ZERO32 = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_M_ROWS    = 3'd0,
    CFG_N_COLS    = 3'd1,
    CFG_K_DEPTH   = 3'd2,
    CFG_ALPHA     = 3'd3,
    CFG_BETA      = 3'd4,
    CFG_BETA_MODE = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  row_index;
    logic [4:0]  col_index;
    logic [31:0] value_bits;
  } in_t;

  typedef struct packed {
    logic [4:0]  out_row;
    logic [4:0]  out_col;
    logic [31:0] result_bits;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } fma_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_RD,
    ST_GO,
    ST_WT,
    ST_ALPHA,
    ST_ALPHA_WT,
    ST_BETA,
    ST_BETA_WT,
    ST_WB
  } sgte_st_e;

  typedef enum logic [3:0] {
    F_IDLE,
    F_LZ,
    F_SH,
    F_SWAP,
    F_ALIGN,
    F_ADD,
    F_TOP,
    F_SHAMT,
    F_RND,
    F_PACK
  } fma_st_e;

  function automatic logic [AW-1:0] mk_addr(input logic [4:0] r, input logic [4:0] c);
    logic [IDX_W-1:0] rr;
    logic [IDX_W-1:0] cc;
    rr = IDX_W'(r);
    cc = IDX_W'(c);
    return {rr, cc};
  endfunction

  function automatic logic [5:0] dim_limit(input logic [5:0] v);
    return (v > 6'(DIM_LIM)) ? 6'(DIM_LIM) : v;
  endfunction

endpackage

// ===== rtl/core/sgte_fma.sv =====
module sgte_fma (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sgte_pkg::fma_req_t req_i,
  output logic              done_o,
  output logic [31:0]       res_o
);
  import sgte_pkg::*;

  fma_st_e             st_q, st_d;
  logic                done_q, done_d;
  logic [31:0]         res_q, res_d;
  logic [63:0]         x_q, x_d, y_q, y_d, s_q, s_d;
  logic signed [EW-1:0] ex_q, ex_d, ey_q, ey_d, d_q, d_d, q_q, q_d, sh_q, sh_d;
  logic                sx_q, sx_d, sy_q, sy_d, sr_q, sr_d, zc_q, zc_d;
  logic [5:0]          lzx_q, lzx_d, lzy_q, lzy_d, t_q, t_d;
  logic [23:0]         mant_q, mant_d;
  logic                rnd_q, rnd_d, stk_q, stk_d;

  function automatic logic [5:0] top_bit(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int n = 0; n < 64; n++) begin
      if (v[n]) r = 6'(n);
    end
    return r;
  endfunction

  logic [7:0]  ea, eb, ec;
  logic [22:0] fa, fb, fc;
  logic        sa, sb, sc, sp, za, zb, zc;
  logic [23:0] ma, mb, mc;
  logic [47:0] prod;
  logic signed [EW-1:0] ean, ebn, ecn;
  logic [63:0] xs, ys, lost_mask, s1;
  logic [5:0]  sh6;
  logic [24:0] m2;
  logic signed [EW-1:0] q2, be;

  assign sa = req_i.a[31];
  assign sb = req_i.b[31];
  assign sc = req_i.c[31];
  assign sp = sa ^ sb;
  assign ea = req_i.a[30:23];
  assign eb = req_i.b[30:23];
  assign ec = req_i.c[30:23];
  assign fa = req_i.a[22:0];
  assign fb = req_i.b[22:0];
  assign fc = req_i.c[22:0];
  assign za = (ea == 8'd0) && (fa == 23'd0);
  assign zb = (eb == 8'd0) && (fb == 23'd0);
  assign zc = (ec == 8'd0) && (fc == 23'd0);
  assign ma = {(ea != 8'd0), fa};
  assign mb = {(eb != 8'd0), fb};
  assign mc = {(ec != 8'd0), fc};
  assign prod = ma * mb;
  assign ean = (ea == 8'd0) ? EW'(1) : EW'({4'd0, ea});
  assign ebn = (eb == 8'd0) ? EW'(1) : EW'({4'd0, eb});
  assign ecn = (ec == 8'd0) ? EW'(1) : EW'({4'd0, ec});

  always_comb begin
    st_d    = st_q;
    done_d  = 1'b0;
    res_d   = res_q;
    x_d     = x_q;
    y_d     = y_q;
    s_d     = s_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    d_d     = d_q;
    q_d     = q_q;
    sh_d    = sh_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    sr_d    = sr_q;
    zc_d    = zc_q;
    lzx_d   = lzx_q;
    lzy_d   = lzy_q;
    t_d     = t_q;
    mant_d  = mant_q;
    rnd_d   = rnd_q;
    stk_d   = stk_q;
    xs      = '0;
    ys      = '0;
    lost_mask = '0;
    s1      = '0;
    sh6     = '0;
    m2      = '0;
    q2      = '0;
    be      = '0;
    unique case (st_q)
      F_IDLE: begin
        if (start_i) begin
          if ((ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0) ||
              (ec == 8'hFF && fc != 23'd0)) begin
            res_d  = QNAN32;
            done_d = 1'b1;
          end else if (ea == 8'hFF || eb == 8'hFF) begin
            if (za || zb || (ec == 8'hFF && sc != sp)) begin
              res_d = QNAN32;
            end else begin
              res_d = {sp, 8'hFF, 23'd0};
            end
            done_d = 1'b1;
          end else if (ec == 8'hFF) begin
            res_d  = req_i.c;
            done_d = 1'b1;
          end else if (za || zb) begin
            if (zc) begin
              res_d = (sp == sc) ? {sp, 31'd0} : 32'd0;
            end else begin
              res_d = req_i.c;
            end
            done_d = 1'b1;
          end else begin
            x_d  = 64'(prod);
            ex_d = ean + ebn - EW'(300);
            y_d  = 64'(mc);
            ey_d = ecn - EW'(150);
            sx_d = sp;
            sy_d = sc;
            zc_d = zc;
            st_d = F_LZ;
          end
        end
      end
      F_LZ: begin
        lzx_d = 6'd61 - top_bit(x_q);
        lzy_d = 6'd61 - top_bit(y_q);
        st_d  = F_SH;
      end
      F_SH: begin
        x_d  = x_q << lzx_q;
        ex_d = ex_q - EW'(lzx_q);
        if (zc_q) begin
          s_d  = x_q << lzx_q;
          sr_d = sx_q;
          st_d = F_TOP;
        end else begin
          y_d  = y_q << lzy_q;
          ey_d = ey_q - EW'(lzy_q);
          st_d = F_SWAP;
        end
      end
      F_SWAP: begin
        if (ex_q < ey_q) begin
          x_d  = y_q;
          y_d  = x_q;
          ex_d = ey_q;
          ey_d = ex_q;
          sx_d = sy_q;
          sy_d = sx_q;
          d_d  = ey_q - ex_q;
        end else begin
          d_d  = ex_q - ey_q;
        end
        st_d = F_ALIGN;
      end
      F_ALIGN: begin
        if (d_q >= EW'(62)) begin
          y_d = 64'd1;
        end else if (d_q > EW'(0)) begin
          sh6       = d_q[5:0];
          lost_mask = (64'd1 << sh6) - 64'd1;
          y_d       = (y_q >> sh6) | 64'(|(y_q & lost_mask));
        end
        st_d = F_ADD;
      end
      F_ADD: begin
        if (sx_q == sy_q) begin
          s_d  = x_q + y_q;
          sr_d = sx_q;
        end else if (x_q >= y_q) begin
          s_d  = x_q - y_q;
          sr_d = sx_q;
        end else begin
          s_d  = y_q - x_q;
          sr_d = sy_q;
        end
        st_d = F_TOP;
      end
      F_TOP: begin
        if (s_q == 64'd0) begin
          res_d  = 32'd0;
          done_d = 1'b1;
          st_d   = F_IDLE;
        end else begin
          t_d  = top_bit(s_q);
          st_d = F_SHAMT;
        end
      end
      F_SHAMT: begin
        q2 = EW'(t_q) - EW'(23) + ex_q;
        if (q2 < -EW'(149)) begin
          q2 = -EW'(149);
        end
        q_d  = q2;
        sh_d = q2 - ex_q;
        st_d = F_RND;
      end
      F_RND: begin
        if (sh_q <= EW'(0)) begin
          sh6    = 6'(-sh_q);
          mant_d = 24'(s_q << sh6);
          rnd_d  = 1'b0;
          stk_d  = 1'b0;
        end else begin
          if (sh_q > EW'(63)) begin
            s1  = 64'd1;
            sh6 = 6'd63;
          end else begin
            s1  = s_q;
            sh6 = sh_q[5:0];
          end
          lost_mask = (64'd1 << (sh6 - 6'd1)) - 64'd1;
          mant_d = 24'(s1 >> sh6);
          rnd_d  = s1[sh6 - 6'd1];
          stk_d  = |(s1 & lost_mask);
        end
        st_d = F_PACK;
      end
      F_PACK: begin
        m2 = {1'b0, mant_q} + 25'(rnd_q && (stk_q || mant_q[0]));
        q2 = q_q;
        if (m2[24]) begin
          m2 = m2 >> 1;
          q2 = q2 + EW'(1);
        end
        be = q2 + EW'(150);
        if (m2[23]) begin
          if (be >= EW'(255)) begin
            res_d = {sr_q, 8'hFF, 23'd0};
          end else begin
            res_d = {sr_q, be[7:0], m2[22:0]};
          end
        end else begin
          res_d = {sr_q, 8'd0, m2[22:0]};
        end
        done_d = 1'b1;
        st_d   = F_IDLE;
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    x_q    <= x_d;
    y_q    <= y_d;
    s_q    <= s_d;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    d_q    <= d_d;
    q_q    <= q_d;
    sh_q   <= sh_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    sr_q   <= sr_d;
    zc_q   <= zc_d;
    lzx_q  <= lzx_d;
    lzy_q  <= lzy_d;
    t_q    <= t_d;
    mant_q <= mant_d;
    rnd_q  <= rnd_d;
    stk_q  <= stk_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/core/sgemm_tile_engine.sv =====
// Single-precision matrix multiply engine computing C = alpha*A*B + beta*C one column at a
// time, the beta term only in beta mode. Load requests for A, B and C write one element each.
// A compute request for column j below the column count, with a nonzero row count, produces
// one result per row in ascending row order, marks the final one as last, and writes each
// result back into C. All arithmetic runs on one shared multi-cycle fused multiply-add unit,
// which sets the rate. Operations with zero or special operands finish sooner, and a stalled
// output holds the engine in write-back. The engine holds off new requests during a compute run.
module sgemm_tile_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sgte_pkg::in_t     in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sgte_pkg::out_t    out_req_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i
);
  import sgte_pkg::*;

  sgte_st_e    st_q, st_d;
  logic [5:0]  m_rows_q, n_cols_q, k_depth_q;
  logic [31:0] alpha_q, beta_q;
  logic        beta_mode_q;
  logic [5:0]  i_q, i_d, k_q, k_d;
  logic [4:0]  col_q, col_d;
  logic [31:0] acc_q, acc_d;
  logic        out_valid_q;
  out_t        out_q;
  logic [5:0]  m_lim, n_lim, k_lim;
  logic        in_acc, in_range, out_free, wb_fire, fma_start, fma_done;
  fma_req_t    fma_req;
  logic [31:0] fma_res;
  logic [31:0] a_mem [DEPTH];
  logic [31:0] b_mem [DEPTH];
  logic [31:0] c_mem [DEPTH];
  logic [31:0] a_rd_q, b_rd_q, c_rd_q;
  logic [AW-1:0] ld_addr, c_waddr;
  logic [31:0] c_wdata;
  logic        c_we;

  assign m_lim    = dim_limit(m_rows_q);
  assign n_lim    = dim_limit(n_cols_q);
  assign k_lim    = dim_limit(k_depth_q);
  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_range = (32'(in_req_i.row_index) < 32'(MAX_DIM)) &&
                    (32'(in_req_i.col_index) < 32'(MAX_DIM));
  assign ld_addr  = mk_addr(in_req_i.row_index, in_req_i.col_index);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_rows_q    <= 6'd32;
      n_cols_q    <= 6'd32;
      k_depth_q   <= 6'd32;
      alpha_q     <= 32'h3F80_0000;
      beta_q      <= 32'd0;
      beta_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_M_ROWS:    m_rows_q    <= cfg_wdata_i[5:0];
        CFG_N_COLS:    n_cols_q    <= cfg_wdata_i[5:0];
        CFG_K_DEPTH:   k_depth_q   <= cfg_wdata_i[5:0];
        CFG_ALPHA:     alpha_q     <= cfg_wdata_i;
        CFG_BETA:      beta_q      <= cfg_wdata_i;
        CFG_BETA_MODE: beta_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d      = st_q;
    i_d       = i_q;
    k_d       = k_q;
    col_d     = col_q;
    acc_d     = acc_q;
    fma_start = 1'b0;
    fma_req   = '{a: acc_q, b: alpha_q, c: NEG_ZERO32};
    wb_fire   = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc && in_req_i.op == OP_COMPUTE) begin
          col_d = in_req_i.col_index;
          i_d   = 6'd0;
          if (({1'b0, in_req_i.col_index} < n_lim) && (m_lim != 6'd0)) begin
            st_d = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        acc_d = 32'd0;
        k_d   = 6'd0;
        st_d  = (k_lim == 6'd0) ? ST_ALPHA : ST_RD;
      end
      ST_RD: st_d = ST_GO;
      ST_GO: begin
        fma_start = 1'b1;
        fma_req   = '{a: a_rd_q, b: b_rd_q, c: acc_q};
        st_d      = ST_WT;
      end
      ST_WT: begin
        if (fma_done) begin
          acc_d = fma_res;
          k_d   = k_q + 6'd1;
          st_d  = (k_q + 6'd1 == k_lim) ? ST_ALPHA : ST_RD;
        end
      end
      ST_ALPHA: begin
        fma_start = 1'b1;
        st_d      = ST_ALPHA_WT;
      end
      ST_ALPHA_WT: begin
        if (fma_done) begin
          acc_d = fma_res;
          st_d  = beta_mode_q ? ST_BETA : ST_WB;
        end
      end
      ST_BETA: begin
        fma_start = 1'b1;
        fma_req   = '{a: c_rd_q, b: beta_q, c: acc_q};
        st_d      = ST_BETA_WT;
      end
      ST_BETA_WT: begin
        if (fma_done) begin
          acc_d = fma_res;
          st_d  = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          wb_fire = 1'b1;
          i_d     = i_q + 6'd1;
          st_d    = (i_q + 6'd1 == m_lim) ? ST_IDLE : ST_ROW;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= wb_fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    k_q   <= k_d;
    col_q <= col_d;
    acc_q <= acc_d;
    if (wb_fire) begin
      out_q.out_row     <= i_q[4:0];
      out_q.out_col     <= col_q;
      out_q.result_bits <= acc_q;
      out_q.last        <= (i_q + 6'd1 == m_lim);
    end
  end

  assign c_we    = wb_fire || (in_acc && in_req_i.op == OP_LOAD_C && in_range);
  assign c_waddr = wb_fire ? mk_addr(i_q[4:0], col_q) : ld_addr;
  assign c_wdata = wb_fire ? acc_q : in_req_i.value_bits;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_req_i.op == OP_LOAD_A && in_range) begin
      a_mem[ld_addr] <= in_req_i.value_bits;
    end
    a_rd_q <= a_mem[mk_addr(i_q[4:0], k_q[4:0])];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_req_i.op == OP_LOAD_B && in_range) begin
      b_mem[ld_addr] <= in_req_i.value_bits;
    end
    b_rd_q <= b_mem[mk_addr(k_q[4:0], col_q)];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    c_rd_q <= c_mem[mk_addr(i_q[4:0], col_q)];
  end

  sgte_fma u_fma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fma_start),
    .req_i   (fma_req),
    .done_o  (fma_done),
    .res_o   (fma_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef SYNTHESIS
  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_IDLE |-> !fma_done)
    else $error("multiply-add finished while no compute run was active");

  a_wb_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_fire |=> out_valid_o)
    else $error("written-back result was not presented on the output");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_acc && in_req_i.op == OP_COMPUTE))
    else $error("engine became busy without a compute request");
`endif

endmodule

// ===== tb/tb_sgemm_tile_engine.sv =====
`timescale 1ns / 100ps

module tb_sgemm_tile_engine;
  import sgte_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE = 40;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    in_t         req;
    bit          fixed;
    logic [31:0] want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_req_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  logic [31:0] a_mem [MAX_DIM*MAX_DIM];
  logic [31:0] b_mem [MAX_DIM*MAX_DIM];
  logic [31:0] c_mem [MAX_DIM*MAX_DIM];
  logic [5:0]  rows_cfg, cols_cfg, depth_cfg;
  logic [31:0] alpha_cfg, beta_cfg;
  logic        beta_on;

  out_t        pending_results [$];
  int          errors;
  int          cycles;
  bit          calm;
  bit          fixed_on;
  logic [31:0] fixed_bits;
  dir_row_t    script [24];

  sgemm_tile_engine DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] round_to_single(bit sign, logic [63:0] s, int e);
    int          t, q, sh, be;
    logic [63:0] mant, rem, half;
    t = 62;
    while (s[t] == 1'b0) t--;
    q = t - 23 + e;
    if (q < -149) q = -149;
    sh = q - e;
    if (sh <= 0) begin
      mant = s << (-sh);
    end else begin
      if (sh > 63) begin
        s = (s != 0) ? 64'd1 : 64'd0;
        sh = 63;
      end
      mant = s >> sh;
      rem = s & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant++;
    end
    if (mant >= (64'd1 << 24)) begin
      mant >>= 1;
      q++;
    end
    if (mant >= (64'd1 << 23)) begin
      be = q + 150;
      if (be >= 255) return {sign, 8'hFF, 23'd0};
      return {sign, be[7:0], mant[22:0]};
    end
    return {sign, 8'd0, mant[22:0]};
  endfunction

  function automatic logic [31:0] fused_mul_add(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    bit          sp, sc, sx, sy, sr, ts, za, zb, zc;
    int          ea, eb, ec, ex, ey, d, te;
    logic [63:0] x, y, s, tv, lost;
    sp = a[31] ^ b[31];
    sc = c[31];
    ea = a[30:23];
    eb = b[30:23];
    ec = c[30:23];
    za = (ea == 0 && a[22:0] == 0);
    zb = (eb == 0 && b[22:0] == 0);
    zc = (ec == 0 && c[22:0] == 0);
    if ((ea == 255 && a[22:0] != 0) || (eb == 255 && b[22:0] != 0) ||
        (ec == 255 && c[22:0] != 0)) return QNAN32;
    if (ea == 255 || eb == 255) begin
      if (za || zb) return QNAN32;
      if (ec == 255 && sc != sp) return QNAN32;
      return {sp, 8'hFF, 23'd0};
    end
    if (ec == 255) return c;
    if (za || zb) begin
      if (zc) return (sp == sc) ? {sp, 31'd0} : 32'd0;
      return c;
    end
    x = {40'd0, (ea != 0), a[22:0]} * {40'd0, (eb != 0), b[22:0]};
    ex = (ea != 0 ? ea : 1) + (eb != 0 ? eb : 1) - 300;
    if (zc) return round_to_single(sp, x, ex);
    y = {40'd0, (ec != 0), c[22:0]};
    ey = (ec != 0 ? ec : 1) - 150;
    while (x[61] == 1'b0) begin
      x <<= 1;
      ex--;
    end
    while (y[61] == 1'b0) begin
      y <<= 1;
      ey--;
    end
    sx = sp;
    sy = sc;
    if (ex < ey) begin
      tv = x; te = ex; ts = sx;
      x = y; ex = ey; sx = sy;
      y = tv; ey = te; sy = ts;
    end
    d = ex - ey;
    if (d >= 62) begin
      y = 64'd1;
    end else if (d > 0) begin
      lost = y & ((64'd1 << d) - 64'd1);
      y >>= d;
      if (lost != 0) y |= 64'd1;
    end
    if (sx == sy) begin
      s = x + y;
      sr = sx;
    end else if (x >= y) begin
      s = x - y;
      sr = sx;
    end else begin
      s = y - x;
      sr = sy;
    end
    if (s == 0) return 32'd0;
    return round_to_single(sr, s, ex);
  endfunction

  function automatic int clamp_dim(logic [5:0] v);
    return (v > DIM_LIM) ? DIM_LIM : int'(v);
  endfunction

  function automatic int slot(int r, int c);
    return r * MAX_DIM + c;
  endfunction

  function automatic void set_register(cfg_idx_e idx, logic [31:0] v);
    case (idx)
      CFG_M_ROWS:    rows_cfg = v[5:0];
      CFG_N_COLS:    cols_cfg = v[5:0];
      CFG_K_DEPTH:   depth_cfg = v[5:0];
      CFG_ALPHA:     alpha_cfg = v;
      CFG_BETA:      beta_cfg = v;
      CFG_BETA_MODE: beta_on = v[0];
      default: ;
    endcase
  endfunction

  function automatic void apply_request(in_t r);
    int   m, n, kd;
    logic [31:0] acc, res;
    out_t o;
    if (r.op == OP_LOAD_A) begin
      a_mem[slot(r.row_index, r.col_index)] = r.value_bits;
    end else if (r.op == OP_LOAD_B) begin
      b_mem[slot(r.row_index, r.col_index)] = r.value_bits;
    end else if (r.op == OP_LOAD_C) begin
      c_mem[slot(r.row_index, r.col_index)] = r.value_bits;
    end else begin
      m = clamp_dim(rows_cfg);
      n = clamp_dim(cols_cfg);
      kd = clamp_dim(depth_cfg);
      if (r.col_index < n && m != 0) begin
        for (int i = 0; i < m; i++) begin
          acc = 32'd0;
          for (int k = 0; k < kd; k++)
            acc = fused_mul_add(a_mem[slot(i, k)], b_mem[slot(k, r.col_index)], acc);
          res = fused_mul_add(acc, alpha_cfg, NEG_ZERO32);
          if (beta_on) res = fused_mul_add(c_mem[slot(i, r.col_index)], beta_cfg, res);
          c_mem[slot(i, r.col_index)] = res;
          o.out_row = i[4:0];
          o.out_col = r.col_index;
          o.result_bits = fixed_on ? fixed_bits : res;
          o.last = (i + 1 == m);
          pending_results.push_back(o);
        end
      end
    end
  endfunction

  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) == 1, 31'd0};
      1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
      2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
      3: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
      4: return $urandom;
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 144)), 23'($urandom)};
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    set_register(idx, v);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_request(in_t r);
    int gap;
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_request(r);
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_op(op_e op, int r, int c, logic [31:0] v);
    in_t q;
    q.op = op;
    q.row_index = 5'(r);
    q.col_index = 5'(c);
    q.value_bits = v;
    send_request(q);
  endtask

  task automatic run_phase(int m, int n, int kd, int extra);
    wait_idle();
    write_register(CFG_M_ROWS, 32'(m));
    write_register(CFG_N_COLS, 32'(n));
    write_register(CFG_K_DEPTH, 32'(kd));
    write_register(CFG_ALPHA, ($urandom_range(0, 3) == 0) ? pick_float() : 32'h3F80_0000);
    write_register(CFG_BETA, pick_float());
    write_register(CFG_BETA_MODE, 32'($urandom_range(0, 1)));
    in_valid_i <= 1'b0;
    for (int i = 0; i < m; i++)
      for (int k = 0; k < kd; k++) send_op(OP_LOAD_A, i, k, pick_float());
    for (int k = 0; k < kd; k++)
      for (int j = 0; j < n; j++) send_op(OP_LOAD_B, k, j, pick_float());
    if (beta_on)
      for (int i = 0; i < m; i++)
        for (int j = 0; j < n; j++) send_op(OP_LOAD_C, i, j, pick_float());
    for (int e = 0; e < extra; e++) begin
      if ($urandom_range(0, 2) != 0)
        send_op(OP_COMPUTE, 0, $urandom_range(0, 2) == 0 ? $urandom_range(0, 31)
                : $urandom_range(0, n - 1), $urandom);
      else
        send_op(op_e'($urandom_range(0, 2)), $urandom_range(0, 31),
                $urandom_range(0, 31), pick_float());
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result row %0d col %0d bits %h",
                                   out_req_o.out_row, out_req_o.out_col, out_req_o.result_bits);
      end else begin
        w = pending_results.pop_front();
        if (out_req_o.out_row !== w.out_row || out_req_o.out_col !== w.out_col ||
            out_req_o.result_bits !== w.result_bits || out_req_o.last !== w.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected row %0d col %0d bits %h last %0b, got %0d %0d %h %0b",
                     w.out_row, w.out_col, w.result_bits, w.last, out_req_o.out_row,
                     out_req_o.out_col, out_req_o.result_bits, out_req_o.last);
        end
      end
    end
  end

  initial begin
    int n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 16);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  function automatic dir_row_t cfg_row(cfg_idx_e idx, logic [31:0] v);
    dir_row_t d;
    d.is_cfg = 1'b1;
    d.idx = idx;
    d.req = '0;
    d.req.value_bits = v;
    d.fixed = 1'b0;
    d.want = '0;
    return d;
  endfunction

  function automatic dir_row_t req_row(op_e op, int r, int c, logic [31:0] v,
                                       bit fx, logic [31:0] want);
    dir_row_t d;
    d.is_cfg = 1'b0;
    d.idx = CFG_M_ROWS;
    d.req.op = op;
    d.req.row_index = 5'(r);
    d.req.col_index = 5'(c);
    d.req.value_bits = v;
    d.fixed = fx;
    d.want = want;
    return d;
  endfunction

  initial begin
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    fixed_on = 1'b0;
    fixed_bits = '0;
    for (int i = 0; i < MAX_DIM * MAX_DIM; i++) begin
      a_mem[i] = '0;
      b_mem[i] = '0;
      c_mem[i] = '0;
    end
    rows_cfg = 6'd32;
    cols_cfg = 6'd32;
    depth_cfg = 6'd32;
    alpha_cfg = 32'h3F80_0000;
    beta_cfg = 32'd0;
    beta_on = 1'b1;

    script[0]  = cfg_row(CFG_M_ROWS, 32'd1);
    script[1]  = cfg_row(CFG_N_COLS, 32'd1);
    script[2]  = cfg_row(CFG_K_DEPTH, 32'd1);
    script[3]  = cfg_row(CFG_BETA_MODE, 32'd0);
    script[4]  = req_row(OP_LOAD_A, 0, 0, 32'h4000_0000, 0, '0);
    script[5]  = req_row(OP_LOAD_B, 0, 0, 32'h4040_0000, 0, '0);
    script[6]  = req_row(OP_COMPUTE, 0, 0, 32'hFFFF_FFFF, 1, 32'h40C0_0000);
    script[7]  = req_row(OP_LOAD_A, 0, 0, 32'h7F80_0000, 0, '0);
    script[8]  = req_row(OP_LOAD_B, 0, 0, 32'h0000_0000, 0, '0);
    script[9]  = req_row(OP_COMPUTE, 0, 0, 32'd0, 1, QNAN32);
    script[10] = req_row(OP_COMPUTE, 0, 31, 32'd0, 0, '0);
    script[11] = cfg_row(CFG_K_DEPTH, 32'd0);
    script[12] = cfg_row(CFG_BETA, 32'h4000_0000);
    script[13] = cfg_row(CFG_BETA_MODE, 32'd1);
    script[14] = req_row(OP_LOAD_C, 0, 0, 32'h3F80_0000, 0, '0);
    script[15] = req_row(OP_COMPUTE, 31, 0, 32'd0, 1, 32'h4000_0000);
    script[16] = cfg_row(CFG_BETA_MODE, 32'd0);
    script[17] = cfg_row(CFG_M_ROWS, 32'd63);
    script[18] = cfg_row(CFG_N_COLS, 32'd63);
    script[19] = req_row(OP_COMPUTE, 0, 31, 32'd0, 1, 32'h0000_0000);
    script[20] = cfg_row(CFG_ALPHA, 32'hFFC0_0001);
    script[21] = req_row(OP_COMPUTE, 0, 5, 32'd0, 1, QNAN32);
    script[22] = cfg_row(CFG_M_ROWS, 32'd0);
    script[23] = req_row(OP_COMPUTE, 0, 0, 32'd0, 0, '0);

    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_req_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[s]) begin
      if (script[s].is_cfg) begin
        in_valid_i <= 1'b0;
        wait_idle();
        write_register(script[s].idx, script[s].req.value_bits);
      end else begin
        fixed_on = script[s].fixed;
        fixed_bits = script[s].want;
        send_request(script[s].req);
        fixed_on = 1'b0;
      end
    end
    in_valid_i <= 1'b0;

    for (int p = 0; p < 7; p++) begin
      calm = (p % 3 == 2);
      run_phase($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 4), 8);
    end
    calm = 1'b0;

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sgemm_tile_engine.f =====
rtl/core/sgte_pkg.sv
rtl/core/sgte_fma.sv
rtl/core/sgemm_tile_engine.sv
tb/tb_sgemm_tile_engine.sv
